// ===== design/qpr_pkg.sv =====
// Shared types, widths and constants for the quaternion point rotation pipeline.
`timescale 1ns / 1ps

package qpr_pkg;

    // Field widths of the payload and configuration registers.
    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;

    // Width of one product of two quaternion components.
    localparam int PROD_W = 2 * QUAT_W;
    // Width of one rotation matrix element (sum of products, times two).
    localparam int MAT_W = 2 * QUAT_W + 2;
    // The matrix element is split in a low unsigned half and a high signed half.
    localparam int LO_W = MAT_W / 2;
    localparam int HI_W = MAT_W - LO_W;
    localparam int PPL_W = LO_W + 1 + COORD_W;
    localparam int PPH_W = HI_W + COORD_W;
    // Full product of a matrix element and a coordinate.
    localparam int ELEM_W = MAT_W + COORD_W;
    // Row sum of three products, with headroom for the rounding constant.
    localparam int ACC_W = MAT_W + COORD_W + 2;
    // Fraction bits dropped at the output.
    localparam int OUT_SHIFT = 2 * (QUAT_W - 2);
    localparam int SHR_W = ACC_W - OUT_SHIFT;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
    localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1) <<< (QUAT_W - 2);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_QUAT_X = 2'd0,
        REG_QUAT_Y = 2'd1,
        REG_QUAT_Z = 2'd2,
        REG_QUAT_W = 2'd3
    } cfg_reg_t;

    typedef logic signed [MAT_W-1:0] mat_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
        logic signed [COORD_W-1:0] rotated_z;
        logic                      saturated;
    } point_out_t;

    // Load enables of the pipeline stages, in flow order.
    typedef struct packed {
        logic prod;
        logic mat;
        logic part;
        logic elem;
        logic row;
        logic out;
    } pipe_en_t;

endpackage

// ===== design/quaternion_point_rotate_unit.sv =====
// Top level of the quaternion point rotation unit: registers, flow control, stages.
// Throughput: one transaction per cycle; each stage holds only while everything
// after it is full and the output is stalled, so empty slots are squeezed out.
// Reset clears all valid bits and sets the quaternion to identity (w = 1.0).
`timescale 1ns / 1ps

module quaternion_point_rotate_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [qpr_pkg::QUAT_W-1:0]          cfg_data,
    // Point input channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  qpr_pkg::point_in_t                  in_data,
    // Rotated point output channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output qpr_pkg::point_out_t                 out_data
);

    // Six register stages: component products, matrix, partial products,
    // element products, row sums and the output register.
    localparam int STAGES = 6;

    qpr_pkg::quat_t      quat_reg;
    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   valid_next;
    logic [STAGES-1:0]   load;
    qpr_pkg::pipe_en_t   en;
    qpr_pkg::mat_t       mat [9];
    qpr_pkg::point_in_t  point_s2;
    qpr_pkg::acc_t       row_sum [3];

    // Configuration registers. The user writes only while no transaction is in
    // flight, so stages see no half written quaternion; not enforced by the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
            quat_reg.w <= qpr_pkg::QUAT_ONE;
        end
        else if (cfg_we)
        begin
            case (qpr_pkg::cfg_reg_t'(cfg_index))
                qpr_pkg::REG_QUAT_X: quat_reg.x <= cfg_data;
                qpr_pkg::REG_QUAT_Y: quat_reg.y <= cfg_data;
                qpr_pkg::REG_QUAT_Z: quat_reg.z <= cfg_data;
                qpr_pkg::REG_QUAT_W: quat_reg.w <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it loads. The
    // last stage loads when its result is taken or it holds nothing.
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int s = STAGES - 2; s >= 0; s--)
        begin
            load[s] = !valid_reg[s] || load[s + 1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int s = 1; s < STAGES; s++)
        begin
            valid_next[s] = load[s] ? valid_reg[s - 1] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en.prod = load[0];
    assign en.mat  = load[1];
    assign en.part = load[2];
    assign en.elem = load[3];
    assign en.row  = load[4];
    assign en.out  = load[5];

    assign in_stall  = !load[0];
    assign out_valid = valid_reg[STAGES-1];

    qpr_matrix u_matrix (
        .clk       (clk),
        .en        (en),
        .quat      (quat_reg),
        .point     (in_data),
        .mat       (mat),
        .point_out (point_s2)
    );

    qpr_mac u_mac (
        .clk     (clk),
        .en      (en),
        .mat     (mat),
        .point   (point_s2),
        .row_sum (row_sum)
    );

    qpr_round u_round (
        .clk     (clk),
        .en      (en),
        .row_sum (row_sum),
        .result  (out_data)
    );

endmodule

// ===== design/qpr_matrix.sv =====
// Quaternion component products and rotation matrix stages.
`timescale 1ns / 1ps

module qpr_matrix (
    input  logic                 clk,
    input  qpr_pkg::pipe_en_t    en,
    input  qpr_pkg::quat_t       quat,
    input  qpr_pkg::point_in_t   point,
    output qpr_pkg::mat_t        mat [9],
    output qpr_pkg::point_in_t   point_out
);

    localparam int PW = qpr_pkg::PROD_W;
    localparam int MW = qpr_pkg::MAT_W;

    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    qpr_pkg::point_in_t   point_s1_reg;
    qpr_pkg::point_in_t   point_s2_reg;
    qpr_pkg::mat_t        mat_next [9];
    qpr_pkg::mat_t        mat_reg [9];

    // The quaternion is taken with the point, so each point uses the registers
    // as they stood when it was accepted.
    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            ww_reg       <= PW'(quat.w) * PW'(quat.w);
            xx_reg       <= PW'(quat.x) * PW'(quat.x);
            yy_reg       <= PW'(quat.y) * PW'(quat.y);
            zz_reg       <= PW'(quat.z) * PW'(quat.z);
            xy_reg       <= PW'(quat.x) * PW'(quat.y);
            xz_reg       <= PW'(quat.x) * PW'(quat.z);
            yz_reg       <= PW'(quat.y) * PW'(quat.z);
            wx_reg       <= PW'(quat.w) * PW'(quat.x);
            wy_reg       <= PW'(quat.w) * PW'(quat.y);
            wz_reg       <= PW'(quat.w) * PW'(quat.z);
            point_s1_reg <= point;
        end
    end

    always_comb
    begin
        mat_next[0] = MW'(ww_reg) + MW'(xx_reg) - MW'(yy_reg) - MW'(zz_reg);
        mat_next[1] = (MW'(xy_reg) - MW'(wz_reg)) <<< 1;
        mat_next[2] = (MW'(xz_reg) + MW'(wy_reg)) <<< 1;
        mat_next[3] = (MW'(xy_reg) + MW'(wz_reg)) <<< 1;
        mat_next[4] = MW'(ww_reg) - MW'(xx_reg) + MW'(yy_reg) - MW'(zz_reg);
        mat_next[5] = (MW'(yz_reg) - MW'(wx_reg)) <<< 1;
        mat_next[6] = (MW'(xz_reg) - MW'(wy_reg)) <<< 1;
        mat_next[7] = (MW'(yz_reg) + MW'(wx_reg)) <<< 1;
        mat_next[8] = MW'(ww_reg) - MW'(xx_reg) - MW'(yy_reg) + MW'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.mat)
        begin
            mat_reg      <= mat_next;
            point_s2_reg <= point_s1_reg;
        end
    end

    assign mat       = mat_reg;
    assign point_out = point_s2_reg;

endmodule

// ===== design/qpr_mac.sv =====
// Matrix times point: split partial products, element products and row sums.
`timescale 1ns / 1ps

module qpr_mac (
    input  logic                 clk,
    input  qpr_pkg::pipe_en_t    en,
    input  qpr_pkg::mat_t        mat [9],
    input  qpr_pkg::point_in_t   point,
    output qpr_pkg::acc_t        row_sum [3]
);

    localparam int LW  = qpr_pkg::LO_W;
    localparam int MW  = qpr_pkg::MAT_W;
    localparam int PLW = qpr_pkg::PPL_W;
    localparam int PHW = qpr_pkg::PPH_W;
    localparam int EW  = qpr_pkg::ELEM_W;
    localparam int AW  = qpr_pkg::ACC_W;

    logic signed [qpr_pkg::COORD_W-1:0] p_vec [3];
    logic signed [PLW-1:0] pl_next [9];
    logic signed [PHW-1:0] ph_next [9];
    logic signed [PLW-1:0] pl_reg [9];
    logic signed [PHW-1:0] ph_reg [9];
    logic signed [EW-1:0]  elem_next [9];
    logic signed [EW-1:0]  elem_reg [9];
    qpr_pkg::acc_t         row_next [3];
    qpr_pkg::acc_t         row_reg [3];

    assign p_vec[0] = point.point_x;
    assign p_vec[1] = point.point_y;
    assign p_vec[2] = point.point_z;

    // Each matrix element is cut in two so that no multiplier is wider than
    // about one half element by one coordinate.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pl_next[r * 3 + c] = PLW'($signed({1'b0, mat[r * 3 + c][LW-1:0]}))
                                     * PLW'(p_vec[c]);
                ph_next[r * 3 + c] = PHW'($signed(mat[r * 3 + c][MW-1:LW]))
                                     * PHW'(p_vec[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.part)
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            elem_next[i] = (EW'(ph_reg[i]) <<< LW) + EW'(pl_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.elem)
        begin
            elem_reg <= elem_next;
        end
    end

    // The rounding constant is folded into the row sum.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_next[r] = AW'(elem_reg[r * 3]) + AW'(elem_reg[r * 3 + 1])
                          + AW'(elem_reg[r * 3 + 2]) + qpr_pkg::ROUND_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.row)
        begin
            row_reg <= row_next;
        end
    end

    assign row_sum = row_reg;

endmodule

// ===== design/qpr_round.sv =====
// Output stage: drops the fraction bits, saturates and registers the result.
`timescale 1ns / 1ps

module qpr_round (
    input  logic                 clk,
    input  qpr_pkg::pipe_en_t    en,
    input  qpr_pkg::acc_t        row_sum [3],
    output qpr_pkg::point_out_t  result
);

    localparam int CW = qpr_pkg::COORD_W;
    localparam int SW = qpr_pkg::SHR_W;
    localparam int OS = qpr_pkg::OUT_SHIFT;

    logic signed [SW-1:0] shifted [3];
    logic [SW-CW:0]       top_bits [3];
    logic [2:0]           clip;
    logic signed [CW-1:0] comp [3];
    qpr_pkg::point_out_t  result_next;
    qpr_pkg::point_out_t  result_reg;

    // The value fits when every bit above the output sign repeats that sign.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            shifted[r]  = row_sum[r][qpr_pkg::ACC_W-1:OS];
            top_bits[r] = shifted[r][SW-1:CW-1];
            clip[r]     = !((&top_bits[r]) || !(|top_bits[r]));
            if (clip[r])
            begin
                comp[r] = shifted[r][SW-1] ? qpr_pkg::COORD_MIN : qpr_pkg::COORD_MAX;
            end
            else
            begin
                comp[r] = shifted[r][CW-1:0];
            end
        end
        result_next.rotated_x = comp[0];
        result_next.rotated_y = comp[1];
        result_next.rotated_z = comp[2];
        result_next.saturated = |clip;
    end

    always_ff @(posedge clk)
    begin
        if (en.out)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== design/qpr_checker.sv =====
// Port level checks of the quaternion point rotation unit and their binding.
`timescale 1ns / 1ps

module qpr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  qpr_pkg::point_out_t                 out_data
);

    // The input only backs up when the whole pipeline is full behind a
    // stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output was free");

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output transaction changed");

    // A clipped result has at least one component at a rail.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.saturated) |->
            (out_data.rotated_x == qpr_pkg::COORD_MAX
             || out_data.rotated_x == qpr_pkg::COORD_MIN
             || out_data.rotated_y == qpr_pkg::COORD_MAX
             || out_data.rotated_y == qpr_pkg::COORD_MIN
             || out_data.rotated_z == qpr_pkg::COORD_MAX
             || out_data.rotated_z == qpr_pkg::COORD_MIN))
    else $error("saturated flag without a clipped component");

    // With the output free, an accepted point shows a result once it has passed every stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
            ##1 !out_stall |=> ##1 out_valid)
    else $error("result missing after the pipeline latency");

endmodule

bind quaternion_point_rotate_unit qpr_checker u_qpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== verif/quaternion_point_rotate_unit_tb.sv =====
// Self-checking testbench for the quaternion point rotation unit.
`timescale 1ns / 1ps

module quaternion_point_rotate_unit_tb;

    // Quiet cycles waited after the last result, to be sure that nothing is
    // still moving through the unit.
    localparam int DRAIN_CYCLES   = 12;
    // Each random phase sends two halves with a full drain in between.
    localparam int ITEMS_PER_HALF = 70;
    localparam int RANDOM_PHASES  = 8;

    // Idling modes of the sender and the receiver.
    localparam int MODE_FLAT        = 0;
    localparam int MODE_SENDER_IDLE = 1;
    localparam int MODE_RECV_STALL  = 2;
    localparam int MODE_BOTH        = 3;

    // Every input of the unit starts from a known value at time zero; reset
    // is driven from the stimulus block so that its falling edge is seen.
    logic                       clk       = 1'b0;
    logic                       rst_n;
    logic                       cfg_we    = 1'b0;
    logic [1:0]                 cfg_index = '0;
    logic [qpr_pkg::QUAT_W-1:0] cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    qpr_pkg::point_in_t         in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    qpr_pkg::point_out_t        out_data;

    // Points waiting to be offered, and rotated points waiting to come out.
    qpr_pkg::point_in_t  pending_points[$];
    qpr_pkg::point_out_t expected_rotations[$];

    // Our own copy of the quaternion registers, identity after reset.
    qpr_pkg::quat_t rot_q;

    // Percentages of cycles in which the sender idles or the receiver stalls.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;

    quaternion_point_rotate_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Expected rotation of one point. The point is rotated by the matrix form
    // of q * p * conj(q), built from the raw components without normalizing,
    // so a non-unit quaternion also scales the point by |q|^2. Each row sum is
    // kept exact in 128 bits, then rounded half up (add half an LSB and shift
    // arithmetically) and clipped to the signed coordinate range.
    function automatic qpr_pkg::point_out_t rotate_point(input qpr_pkg::quat_t q,
                                                         input qpr_pkg::point_in_t pt);
        longint                      qx, qy, qz, qw;
        longint                      mat [3][3];
        logic signed [127:0]         coord [3];
        logic signed [127:0]         elem, acc;
        logic [qpr_pkg::COORD_W-1:0] comp [3];
        logic                        clipped;
        qpr_pkg::point_out_t         res;
        qx = q.x;
        qy = q.y;
        qz = q.z;
        qw = q.w;
        mat[0][0] = qw * qw + qx * qx - qy * qy - qz * qz;
        mat[0][1] = 2 * (qx * qy - qw * qz);
        mat[0][2] = 2 * (qx * qz + qw * qy);
        mat[1][0] = 2 * (qx * qy + qw * qz);
        mat[1][1] = qw * qw - qx * qx + qy * qy - qz * qz;
        mat[1][2] = 2 * (qy * qz - qw * qx);
        mat[2][0] = 2 * (qx * qz - qw * qy);
        mat[2][1] = 2 * (qy * qz + qw * qx);
        mat[2][2] = qw * qw - qx * qx - qy * qy + qz * qz;
        coord[0] = pt.point_x;
        coord[1] = pt.point_y;
        coord[2] = pt.point_z;
        clipped = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            acc = '0;
            for (int c = 0; c < 3; c++)
            begin
                elem = mat[r][c];
                acc = acc + elem * coord[c];
            end
            acc = (acc + (128'sd1 <<< (qpr_pkg::OUT_SHIFT - 1))) >>> qpr_pkg::OUT_SHIFT;
            if (acc > qpr_pkg::COORD_MAX)
            begin
                comp[r] = qpr_pkg::COORD_MAX;
                clipped = 1'b1;
            end
            else if (acc < qpr_pkg::COORD_MIN)
            begin
                comp[r] = qpr_pkg::COORD_MIN;
                clipped = 1'b1;
            end
            else
            begin
                comp[r] = acc[qpr_pkg::COORD_W-1:0];
            end
        end
        res.rotated_x = comp[0];
        res.rotated_y = comp[1];
        res.rotated_z = comp[2];
        res.saturated = clipped;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic add_point(input logic [qpr_pkg::COORD_W-1:0] x,
                             input logic [qpr_pkg::COORD_W-1:0] y,
                             input logic [qpr_pkg::COORD_W-1:0] z);
        qpr_pkg::point_in_t pt;
        pt.point_x = x;
        pt.point_y = y;
        pt.point_z = z;
        pending_points.push_back(pt);
    endtask

    // Flat mode runs flat out; the other modes idle the sender, stall the
    // receiver, or do a lighter amount of both.
    task automatic set_idle_mode(input int mode);
        case (mode)
            MODE_FLAT:
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            MODE_SENDER_IDLE:
            begin
                sender_idle_pct = 63;
                recv_stall_pct  = 0;
            end
            MODE_RECV_STALL:
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 63;
            end
            default:
            begin
                sender_idle_pct = 23;
                recv_stall_pct  = 23;
            end
        endcase
    endtask

    // Waits until every queued point has been taken and every expected result
    // has arrived, then lets the pipeline run empty for a further drain period.
    // Sampling on the falling edge keeps clear of the driver and monitor.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_points.size() != 0 || in_valid || expected_rotations.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes all four quaternion registers, one per enabled clock edge, with
    // cfg_we low between writes. Only ever called while the unit is idle.
    task automatic write_quaternion(input qpr_pkg::quat_t q);
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= qpr_pkg::cfg_reg_t'(i);
            case (qpr_pkg::cfg_reg_t'(i))
                qpr_pkg::REG_QUAT_X: cfg_data <= q.x;
                qpr_pkg::REG_QUAT_Y: cfg_data <= q.y;
                qpr_pkg::REG_QUAT_Z: cfg_data <= q.z;
                default:             cfg_data <= q.w;
            endcase
            @(posedge clk);
            cfg_we <= 1'b0;
        end
        rot_q = q;
    endtask

    // Mostly full-range random coordinates, with a share of small values that
    // stay clear of saturation and a few hits on the range limits.
    function automatic logic [qpr_pkg::COORD_W-1:0] rand_coord();
        logic [qpr_pkg::COORD_W-1:0] v;
        case ($urandom_range(9))
            0: v = qpr_pkg::COORD_MAX;
            1: v = qpr_pkg::COORD_MIN;
            2, 3, 4: v = $urandom_range(0, 2097151) - 1048576;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Style 0 is any 16-bit value, style 1 keeps each component within +/-1.0,
    // and style 2 picks corner values.
    function automatic logic [qpr_pkg::QUAT_W-1:0] rand_quat_comp(input int style);
        logic [qpr_pkg::QUAT_W-1:0] v;
        case (style)
            0: v = qpr_pkg::QUAT_W'($urandom);
            1: v = qpr_pkg::QUAT_W'($urandom_range(0, 32768) - 16384);
            default:
                case ($urandom_range(4))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = qpr_pkg::QUAT_ONE;
                    3: v = -qpr_pkg::QUAT_ONE;
                    default: v = '0;
                endcase
        endcase
        return v;
    endfunction

    // Driver: offers the next pending point once the current transaction has
    // been taken (or nothing is on offer). A stalled point is held unchanged,
    // and the expected rotation is computed at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_rotations.push_back(rotate_point(rot_q, in_data));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_points.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: every accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        qpr_pkg::point_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rotations.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected: %h", out_data));
            end
            else
            begin
                want = expected_rotations.pop_front();
                if (out_data.rotated_x !== want.rotated_x)
                    report_mismatch($sformatf("rotated_x got %0d want %0d",
                                              out_data.rotated_x, want.rotated_x));
                if (out_data.rotated_y !== want.rotated_y)
                    report_mismatch($sformatf("rotated_y got %0d want %0d",
                                              out_data.rotated_y, want.rotated_y));
                if (out_data.rotated_z !== want.rotated_z)
                    report_mismatch($sformatf("rotated_z got %0d want %0d",
                                              out_data.rotated_z, want.rotated_z));
                if (out_data.saturated !== want.saturated)
                    report_mismatch($sformatf("saturated got %b want %b",
                                              out_data.saturated, want.saturated));
            end
        end
    end

    initial
    begin
        qpr_pkg::quat_t q;
        int             style;
        rot_q = '{x: '0, y: '0, z: '0, w: qpr_pkg::QUAT_ONE};
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: the identity quaternion must pass points through
        // unchanged, extremes included.
        set_idle_mode(MODE_FLAT);
        add_point(32'd0, 32'd0, 32'd0);
        add_point(qpr_pkg::COORD_MAX, qpr_pkg::COORD_MAX, qpr_pkg::COORD_MAX);
        add_point(qpr_pkg::COORD_MIN, qpr_pkg::COORD_MIN, qpr_pkg::COORD_MIN);
        add_point(qpr_pkg::COORD_MAX, qpr_pkg::COORD_MIN, 32'd1);
        add_point(32'hFFFF_FFFF, 32'd0, qpr_pkg::COORD_MIN);
        add_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);

        // Corner quaternion with every component at a range limit: the point
        // is scaled far beyond the output range and clips both ways.
        wait_drained();
        write_quaternion(qpr_pkg::quat_t'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        set_idle_mode(MODE_SENDER_IDLE);
        add_point(qpr_pkg::COORD_MAX, qpr_pkg::COORD_MAX, qpr_pkg::COORD_MAX);
        add_point(qpr_pkg::COORD_MIN, qpr_pkg::COORD_MIN, qpr_pkg::COORD_MIN);
        add_point(qpr_pkg::COORD_MAX, qpr_pkg::COORD_MIN, qpr_pkg::COORD_MAX);
        add_point(32'd0, 32'd0, 32'd0);
        add_point(32'd1, 32'hFFFF_FFFF, 32'd1);

        // A tiny w leaves the point scaled by 2^-28, so coordinates at exact
        // halves show round half up, including negative halves toward zero.
        wait_drained();
        write_quaternion(qpr_pkg::quat_t'{16'h0000, 16'h0000, 16'h0000, 16'h0001});
        set_idle_mode(MODE_RECV_STALL);
        add_point(32'd134217728, -32'sd134217728, 32'd402653184);
        add_point(-32'sd402653184, 32'd134217727, -32'sd134217729);

        // An all-zero quaternion maps everything to the origin.
        wait_drained();
        write_quaternion(qpr_pkg::quat_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
        add_point(qpr_pkg::COORD_MAX, qpr_pkg::COORD_MIN, qpr_pkg::COORD_MAX);

        // A quarter turn about z, close to unit length.
        wait_drained();
        write_quaternion(qpr_pkg::quat_t'{16'h0000, 16'h0000, 16'sd11585, 16'sd11585});
        set_idle_mode(MODE_BOTH);
        add_point(32'd65536, 32'd0, 32'd0);
        add_point(32'd0, 32'd65536, 32'd0);
        add_point(32'd0, 32'd0, 32'd65536);
        add_point(-32'sd65536, 32'd123456, -32'sd7);

        // Random phases: a fresh quaternion for each, cycling through the
        // idling modes. Midway the sender holds off until all results are in.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            style = $urandom_range(2);
            q.x = rand_quat_comp(style);
            q.y = rand_quat_comp(style);
            q.z = rand_quat_comp(style);
            q.w = rand_quat_comp(style);
            write_quaternion(q);
            set_idle_mode(ph % 4);
            repeat (ITEMS_PER_HALF) add_point(rand_coord(), rand_coord(), rand_coord());
            wait_drained();
            repeat (ITEMS_PER_HALF) add_point(rand_coord(), rand_coord(), rand_coord());
        end

        wait_drained();
        if (error_count == 0)
            $display("[quaternion_point_rotate_unit] OK");
        else
            $display("[quaternion_point_rotate_unit] ERROR");
        $finish;
    end

    // Watchdog: a hung handshake or a lost result ends the run as a failure.
    initial
    begin
        #5_000_000;
        $display("[quaternion_point_rotate_unit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qpr_pkg.sv
design/qpr_matrix.sv
design/qpr_mac.sv
design/qpr_round.sv
design/quaternion_point_rotate_unit.sv
design/qpr_checker.sv
verif/quaternion_point_rotate_unit_tb.sv
